### src/nls_pkg.sv
// Shared types and constants for the numeric literal scanner.
// Holds the scan phases, the suffix and error codes, byte codes and the result record.
// No dependencies.
package nls_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 4095;
  localparam int TOKEN_LEN_W       = 12;
  localparam int TOKEN_LEN_CAP     = 4095;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEAD_DOT,
    PH_DEC_INT,
    PH_DEC_FRAC,
    PH_DEC_EXP_START,
    PH_DEC_EXP_SIGN,
    PH_DEC_EXP_DIGITS,
    PH_HEX_INT,
    PH_HEX_FRAC,
    PH_HEX_EXP_START,
    PH_HEX_EXP_SIGN,
    PH_HEX_EXP_DIGITS
  } phase_t;

  typedef enum logic [2:0] {
    SUF_NONE,
    SUF_I,
    SUF_U,
    SUF_F,
    SUF_H
  } suffix_t;

  typedef enum logic [3:0] {
    ERR_OK,
    ERR_DEC_EXP_EMPTY,
    ERR_HEX_EXP_EMPTY,
    ERR_HEX_INT_EMPTY,
    ERR_HEX_FLOAT_EMPTY,
    ERR_HEX_DOT_NO_EXP,
    ERR_LEADING_ZERO,
    ERR_HEX_H_SUFFIX,
    ERR_BAD_START
  } error_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_U  = 8'h75;

  localparam int HP_INT  = 0;
  localparam int HP_DOT  = 1;
  localparam int HP_FRAC = 2;
  localparam int HP_EXP  = 3;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] int_digit_count;
    logic       first_digit_zero;
    logic       saw_float_mark;
    logic       saw_hex_prefix;
    logic [3:0] hex_parts_seen;
  } scan_state_t;

  typedef struct packed {
    logic                   consumed;
    logic                   done_res;
    logic                   float_flag;
    suffix_t                suffix_code;
    logic                   is_hex;
    logic [TOKEN_LEN_W-1:0] token_length;
    error_t                 error_code;
  } result_t;

endpackage

### src/nls_if.sv
// Channel interfaces of the numeric literal scanner: source bytes in, results out.
// Depends on nls_pkg.
interface nls_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, source_byte, end_of_input, input ready);
  modport sink (input valid, source_byte, end_of_input, output ready);
endinterface

interface nls_result_if;
  logic                           valid;
  logic                           ready;
  logic                           consumed;
  logic                           done_res;
  logic                           float_flag;
  logic [2:0]                     suffix_code;
  logic                           is_hex;
  logic [nls_pkg::TOKEN_LEN_W-1:0] token_length;
  logic [3:0]                     error_code;

  modport source (output valid, consumed, done_res, float_flag, suffix_code, is_hex,
                  token_length, error_code, input ready);
  modport sink (input valid, consumed, done_res, float_flag, suffix_code, is_hex,
                token_length, error_code, output ready);
endinterface

### src/nls_step.sv
// Next-state and result logic for one source byte of the scanner.
// Purely combinational; depends on nls_pkg.
module nls_step #(
  parameter int MAX_TOKEN_LEN = nls_pkg::MAX_TOKEN_LEN_DEF,
  parameter int LEN_W         = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  nls_pkg::scan_state_t st,
  input  logic [LEN_W-1:0]     len,
  input  logic [7:0]           source_byte,
  input  logic                 end_of_input,
  output nls_pkg::scan_state_t st_next,
  output logic [LEN_W-1:0]     len_next,
  output nls_pkg::result_t     res
);
  import nls_pkg::*;

  localparam int CAP = (MAX_TOKEN_LEN < TOKEN_LEN_CAP) ? MAX_TOKEN_LEN : TOKEN_LEN_CAP;

  logic             have, dig, hdig, sign, e_mark, p_mark;
  logic             fin, took;
  phase_t           nxt;
  suffix_t          suf;
  error_t           err;
  scan_state_t      upd;
  logic [LEN_W-1:0] len_took;

  assign have   = !end_of_input;
  assign dig    = have && source_byte >= CH_ZERO && source_byte <= CH_NINE;
  assign hdig   = dig || (have && ((source_byte >= CH_LO_A && source_byte <= CH_LO_F) ||
                                   (source_byte >= CH_UP_A && source_byte <= CH_UP_F)));
  assign sign   = have && (source_byte == CH_PLUS || source_byte == CH_MINUS);
  assign e_mark = have && (source_byte == CH_LO_E || source_byte == CH_UP_E);
  assign p_mark = have && (source_byte == CH_LO_P || source_byte == CH_UP_P);

  always_comb begin
    upd  = st;
    nxt  = st.phase;
    fin  = 1'b0;
    took = 1'b1;
    suf  = SUF_NONE;
    err  = ERR_OK;
    unique case (st.phase)
      PH_IDLE: begin
        if (dig) begin
          upd.int_digit_count  = 2'd1;
          upd.first_digit_zero = (source_byte == CH_ZERO);
          nxt                  = PH_DEC_INT;
        end else if (have && source_byte == CH_DOT) begin
          upd.saw_float_mark = 1'b1;
          nxt                = PH_LEAD_DOT;
        end else begin
          fin = 1'b1; took = 1'b0; err = ERR_BAD_START;
        end
      end
      PH_LEAD_DOT: begin
        if (dig) begin
          nxt = PH_DEC_FRAC;
        end else begin
          fin = 1'b1; took = 1'b0; err = ERR_BAD_START;
        end
      end
      PH_DEC_INT: begin
        if (dig) begin
          if (st.int_digit_count < 2'd2) begin
            upd.int_digit_count = st.int_digit_count + 2'd1;
          end
        end else if (have && (source_byte == CH_LO_X || source_byte == CH_UP_X) &&
                     st.int_digit_count == 2'd1 && st.first_digit_zero) begin
          upd.saw_hex_prefix = 1'b1;
          nxt                = PH_HEX_INT;
        end else if (st.int_digit_count >= 2'd2 && st.first_digit_zero &&
                     !(have && (source_byte == CH_DOT || e_mark || source_byte == CH_LO_F ||
                                source_byte == CH_LO_H))) begin
          fin = 1'b1; took = 1'b0; err = ERR_LEADING_ZERO;
        end else if (have && source_byte == CH_DOT) begin
          upd.saw_float_mark = 1'b1;
          nxt                = PH_DEC_FRAC;
        end else if (e_mark) begin
          upd.saw_float_mark = 1'b1;
          nxt                = PH_DEC_EXP_START;
        end else begin
          fin = 1'b1;
          if (have && source_byte == CH_LO_I) suf = SUF_I;
          else if (have && source_byte == CH_LO_U) suf = SUF_U;
          else if (have && source_byte == CH_LO_F) suf = SUF_F;
          else if (have && source_byte == CH_LO_H) suf = SUF_H;
          else took = 1'b0;
        end
      end
      PH_DEC_FRAC, PH_DEC_EXP_DIGITS: begin
        if (dig) begin
          nxt = st.phase;
        end else if (e_mark && st.phase == PH_DEC_FRAC) begin
          nxt = PH_DEC_EXP_START;
        end else begin
          fin = 1'b1;
          if (have && source_byte == CH_LO_F) suf = SUF_F;
          else if (have && source_byte == CH_LO_H) suf = SUF_H;
          else took = 1'b0;
        end
      end
      PH_DEC_EXP_START: begin
        if (sign) begin
          nxt = PH_DEC_EXP_SIGN;
        end else if (dig) begin
          nxt = PH_DEC_EXP_DIGITS;
        end else begin
          fin = 1'b1; took = 1'b0; err = ERR_DEC_EXP_EMPTY;
        end
      end
      PH_DEC_EXP_SIGN: begin
        if (dig) begin
          nxt = PH_DEC_EXP_DIGITS;
        end else begin
          fin = 1'b1; took = 1'b0; err = ERR_DEC_EXP_EMPTY;
        end
      end
      PH_HEX_INT: begin
        if (hdig) begin
          upd.hex_parts_seen[HP_INT] = 1'b1;
        end else if (have && source_byte == CH_DOT) begin
          upd.hex_parts_seen[HP_DOT] = 1'b1;
          upd.saw_float_mark         = 1'b1;
          nxt                        = PH_HEX_FRAC;
        end else if (p_mark) begin
          upd.hex_parts_seen[HP_EXP] = 1'b1;
          upd.saw_float_mark         = 1'b1;
          nxt                        = PH_HEX_EXP_START;
        end else if (!st.hex_parts_seen[HP_INT]) begin
          fin = 1'b1; took = 1'b0; err = ERR_HEX_INT_EMPTY;
        end else begin
          fin = 1'b1;
          if (have && source_byte == CH_LO_I) suf = SUF_I;
          else if (have && source_byte == CH_LO_U) suf = SUF_U;
          else if (have && source_byte == CH_LO_H) err = ERR_HEX_H_SUFFIX;
          else took = 1'b0;
        end
      end
      PH_HEX_FRAC: begin
        if (hdig) begin
          upd.hex_parts_seen[HP_FRAC] = 1'b1;
        end else if (p_mark) begin
          upd.hex_parts_seen[HP_EXP] = 1'b1;
          nxt                        = PH_HEX_EXP_START;
        end else begin
          fin  = 1'b1;
          took = 1'b0;
          if (!st.hex_parts_seen[HP_INT] && !st.hex_parts_seen[HP_FRAC]) begin
            err = ERR_HEX_FLOAT_EMPTY;
          end else if (!st.hex_parts_seen[HP_FRAC]) begin
            err = ERR_HEX_DOT_NO_EXP;
          end
        end
      end
      PH_HEX_EXP_START: begin
        if (sign) begin
          nxt = PH_HEX_EXP_SIGN;
        end else if (dig) begin
          nxt = PH_HEX_EXP_DIGITS;
        end else begin
          fin = 1'b1; took = 1'b0; err = ERR_HEX_EXP_EMPTY;
        end
      end
      PH_HEX_EXP_SIGN: begin
        if (dig) begin
          nxt = PH_HEX_EXP_DIGITS;
        end else begin
          fin = 1'b1; took = 1'b0; err = ERR_HEX_EXP_EMPTY;
        end
      end
      PH_HEX_EXP_DIGITS: begin
        if (dig) begin
          nxt = PH_HEX_EXP_DIGITS;
        end else if (!st.hex_parts_seen[HP_INT] && !st.hex_parts_seen[HP_FRAC]) begin
          fin = 1'b1; took = 1'b0; err = ERR_HEX_FLOAT_EMPTY;
        end else begin
          fin = 1'b1;
          if (have && source_byte == CH_LO_F) suf = SUF_F;
          else if (have && source_byte == CH_LO_H) suf = SUF_H;
          else took = 1'b0;
        end
      end
      default: begin
        fin = 1'b1; took = 1'b0; err = ERR_BAD_START;
      end
    endcase
  end

  always_comb begin
    len_took = len;
    if (took && len < LEN_W'(MAX_TOKEN_LEN)) begin
      len_took = len + LEN_W'(1);
    end
  end

  always_comb begin
    st_next       = upd;
    st_next.phase = nxt;
    len_next      = len_took;
    if (fin) begin
      st_next  = '0;
      len_next = '0;
    end
  end

  always_comb begin
    res          = '0;
    res.consumed = took;
    res.done_res = fin;
    if (fin) begin
      res.is_hex     = st.saw_hex_prefix;
      res.error_code = err;
      if (len_took > LEN_W'(CAP)) begin
        res.token_length = TOKEN_LEN_W'(CAP);
      end else begin
        res.token_length = TOKEN_LEN_W'(len_took);
      end
      if (err == ERR_OK) begin
        res.suffix_code = suf;
        res.float_flag  = st.saw_float_mark || suf == SUF_F || suf == SUF_H;
      end
    end
  end

endmodule

### src/nls_out_buf.sv
// Result register of the scanner, holding one result until the sink takes it.
// Depends on nls_pkg and nls_result_if.
module nls_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  nls_pkg::result_t    d,
  output logic                can_load,
  nls_result_if.source        result
);
  import nls_pkg::*;

  logic    valid;
  result_t data;

  assign can_load = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= d;
    end
  end

  assign result.valid        = valid;
  assign result.consumed     = data.consumed;
  assign result.done_res     = data.done_res;
  assign result.float_flag   = data.float_flag;
  assign result.suffix_code  = data.suffix_code;
  assign result.is_hex       = data.is_hex;
  assign result.token_length = data.token_length;
  assign result.error_code   = data.error_code;

endmodule

### src/numeric_literal_scanner.sv
// Top level of the numeric literal scanner: state registers, step logic and result register.
// Depends on nls_pkg, nls_if, nls_step and nls_out_buf.
//
// The scanner takes one source byte per request and returns one result per byte, so a new
// byte is accepted in every cycle while the result register is free or being emptied. Each
// byte passes through the step logic in the cycle it is accepted; its result and the next scan
// state are registered together for the next cycle, which gives the one-byte-per-cycle
// figure. A result with done_res set closes the literal and the next byte starts a new one.
module numeric_literal_scanner #(
  parameter int MAX_TOKEN_LEN = nls_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  nls_byte_if.sink     bytes,
  nls_result_if.source result
);
  import nls_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  scan_state_t      st, st_next;
  logic [LEN_W-1:0] len, len_next;
  result_t          step_res;
  logic             can_load;
  logic             accept;

  assign bytes.ready = can_load;
  assign accept      = bytes.valid && can_load;

  nls_step #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .LEN_W         (LEN_W)
  ) u_step (
    .st           (st),
    .len          (len),
    .source_byte  (bytes.source_byte),
    .end_of_input (bytes.end_of_input),
    .st_next      (st_next),
    .len_next     (len_next),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      len <= '0;
    end else if (accept) begin
      st  <= st_next;
      len <= len_next;
    end
  end

  nls_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .d        (step_res),
    .can_load (can_load),
    .result   (result)
  );

endmodule

### tb/nls_result_checker.sv
// Result checker for the numeric literal scanner: predicts every result from the bytes taken in.
// Watches both channels, compares each result field by field and counts failures.
// Depends on nls_pkg and nls_if.
`timescale 1ns / 1ps

module nls_result_checker (
  input  logic   clk,
  input  logic   rst,
  nls_byte_if    bytes,
  nls_result_if  result,
  output int     fail_count,
  output int     pending_count
);
  import nls_pkg::*;

  localparam int LEN_CAP = (MAX_TOKEN_LEN_DEF < TOKEN_LEN_CAP) ? MAX_TOKEN_LEN_DEF : TOKEN_LEN_CAP;

  phase_t     phase;
  int         len;
  logic [1:0] int_digits;
  logic       lead_zero;
  logic       float_mark;
  logic       hex_prefix;
  logic [3:0] hex_parts;

  result_t predicted_results[$];
  int      errs;

  function automatic void clear_scan();
    phase = PH_IDLE;
    len = 0;
    int_digits = '0;
    lead_zero = 1'b0;
    float_mark = 1'b0;
    hex_prefix = 1'b0;
    hex_parts = '0;
  endfunction

  function automatic suffix_t suffix_of(input logic [7:0] c);
    case (c)
      CH_LO_I: return SUF_I;
      CH_LO_U: return SUF_U;
      CH_LO_F: return SUF_F;
      CH_LO_H: return SUF_H;
      default: return SUF_NONE;
    endcase
  endfunction

  function automatic result_t scan_byte(input logic [7:0] c, input logic eoi);
    logic    have, dig, hdig, sgn, emark, pmark, fsuf;
    logic    took, fin;
    suffix_t suf;
    error_t  err;
    phase_t  nxt;
    result_t r;
    have  = !eoi;
    dig   = have && c >= CH_ZERO && c <= CH_NINE;
    hdig  = dig || (have && ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)));
    sgn   = have && (c == CH_PLUS || c == CH_MINUS);
    emark = have && (c == CH_LO_E || c == CH_UP_E);
    pmark = have && (c == CH_LO_P || c == CH_UP_P);
    fsuf  = have && (c == CH_LO_F || c == CH_LO_H);
    took = 1'b1;
    fin  = 1'b0;
    suf  = SUF_NONE;
    err  = ERR_OK;
    nxt  = phase;
    case (phase)
      PH_IDLE: begin
        if (dig) begin
          int_digits = 2'd1;
          lead_zero = (c == CH_ZERO);
          nxt = PH_DEC_INT;
        end else if (have && c == CH_DOT) begin
          float_mark = 1'b1;
          nxt = PH_LEAD_DOT;
        end else begin
          fin = 1'b1;
          took = 1'b0;
          err = ERR_BAD_START;
        end
      end
      PH_LEAD_DOT: begin
        if (dig) begin
          nxt = PH_DEC_FRAC;
        end else begin
          fin = 1'b1;
          took = 1'b0;
          err = ERR_BAD_START;
        end
      end
      PH_DEC_INT: begin
        if (dig) begin
          if (int_digits < 2'd2) int_digits++;
        end else if (have && (c == CH_LO_X || c == CH_UP_X) && int_digits == 2'd1 && lead_zero) begin
          hex_prefix = 1'b1;
          nxt = PH_HEX_INT;
        end else if (int_digits >= 2'd2 && lead_zero &&
                     !(have && (c == CH_DOT || c == CH_LO_E || c == CH_UP_E ||
                                c == CH_LO_F || c == CH_LO_H))) begin
          fin = 1'b1;
          took = 1'b0;
          err = ERR_LEADING_ZERO;
        end else if (have && c == CH_DOT) begin
          float_mark = 1'b1;
          nxt = PH_DEC_FRAC;
        end else if (emark) begin
          float_mark = 1'b1;
          nxt = PH_DEC_EXP_START;
        end else begin
          fin = 1'b1;
          suf = have ? suffix_of(c) : SUF_NONE;
          took = (suf != SUF_NONE);
        end
      end
      PH_DEC_FRAC, PH_DEC_EXP_DIGITS: begin
        if (dig) begin
          nxt = PH_DEC_EXP_DIGITS == phase ? PH_DEC_EXP_DIGITS : PH_DEC_FRAC;
        end else if (emark && phase == PH_DEC_FRAC) begin
          nxt = PH_DEC_EXP_START;
        end else begin
          fin = 1'b1;
          took = fsuf;
          if (fsuf) suf = suffix_of(c);
        end
      end
      PH_DEC_EXP_START, PH_DEC_EXP_SIGN, PH_HEX_EXP_START, PH_HEX_EXP_SIGN: begin
        if (dig) begin
          nxt = (phase == PH_DEC_EXP_START || phase == PH_DEC_EXP_SIGN) ?
                PH_DEC_EXP_DIGITS : PH_HEX_EXP_DIGITS;
        end else if (sgn && phase == PH_DEC_EXP_START) begin
          nxt = PH_DEC_EXP_SIGN;
        end else if (sgn && phase == PH_HEX_EXP_START) begin
          nxt = PH_HEX_EXP_SIGN;
        end else begin
          fin = 1'b1;
          took = 1'b0;
          err = (phase == PH_DEC_EXP_START || phase == PH_DEC_EXP_SIGN) ?
                ERR_DEC_EXP_EMPTY : ERR_HEX_EXP_EMPTY;
        end
      end
      PH_HEX_INT: begin
        if (hdig) begin
          hex_parts[HP_INT] = 1'b1;
        end else if (have && c == CH_DOT) begin
          hex_parts[HP_DOT] = 1'b1;
          float_mark = 1'b1;
          nxt = PH_HEX_FRAC;
        end else if (pmark) begin
          hex_parts[HP_EXP] = 1'b1;
          float_mark = 1'b1;
          nxt = PH_HEX_EXP_START;
        end else if (!hex_parts[HP_INT]) begin
          fin = 1'b1;
          took = 1'b0;
          err = ERR_HEX_INT_EMPTY;
        end else if (have && c == CH_LO_H) begin
          fin = 1'b1;
          err = ERR_HEX_H_SUFFIX;
        end else begin
          fin = 1'b1;
          took = have && (c == CH_LO_I || c == CH_LO_U);
          if (took) suf = suffix_of(c);
        end
      end
      PH_HEX_FRAC: begin
        if (hdig) begin
          hex_parts[HP_FRAC] = 1'b1;
        end else if (pmark) begin
          hex_parts[HP_EXP] = 1'b1;
          nxt = PH_HEX_EXP_START;
        end else begin
          fin = 1'b1;
          took = 1'b0;
          if (!hex_parts[HP_INT] && !hex_parts[HP_FRAC]) err = ERR_HEX_FLOAT_EMPTY;
          else if (!hex_parts[HP_FRAC]) err = ERR_HEX_DOT_NO_EXP;
        end
      end
      PH_HEX_EXP_DIGITS: begin
        if (!dig) begin
          fin = 1'b1;
          if (!hex_parts[HP_INT] && !hex_parts[HP_FRAC]) begin
            took = 1'b0;
            err = ERR_HEX_FLOAT_EMPTY;
          end else begin
            took = fsuf;
            if (fsuf) suf = suffix_of(c);
          end
        end
      end
      default: begin
        fin = 1'b1;
        took = 1'b0;
        err = ERR_BAD_START;
      end
    endcase
    if (took && len < LEN_CAP) len++;
    r = '0;
    r.consumed = took;
    r.done_res = fin;
    if (fin) begin
      r.float_flag = (err == ERR_OK) && (float_mark || suf == SUF_F || suf == SUF_H);
      r.suffix_code = (err == ERR_OK) ? suf : SUF_NONE;
      r.is_hex = hex_prefix;
      r.token_length = TOKEN_LEN_W'(len);
      r.error_code = err;
      clear_scan();
    end else begin
      phase = nxt;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_scan();
      predicted_results.delete();
    end else begin
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (predicted_results.size() == 0) begin
          errs++;
          $error("result received with no request outstanding");
        end else begin
          want = predicted_results.pop_front();
          check_field("consumed", 12'(want.consumed), 12'(result.consumed));
          check_field("done_res", 12'(want.done_res), 12'(result.done_res));
          check_field("float_flag", 12'(want.float_flag), 12'(result.float_flag));
          check_field("suffix_code", 12'(want.suffix_code), 12'(result.suffix_code));
          check_field("is_hex", 12'(want.is_hex), 12'(result.is_hex));
          check_field("token_length", 12'(want.token_length), 12'(result.token_length));
          check_field("error_code", 12'(want.error_code), 12'(result.error_code));
        end
      end
      if (bytes.valid === 1'b1 && bytes.ready === 1'b1)
        predicted_results.push_back(scan_byte(bytes.source_byte, bytes.end_of_input));
    end
    fail_count <= errs;
    pending_count <= predicted_results.size();
  end

endmodule

### tb/numeric_literal_scanner_tb.sv
// Top of the numeric literal scanner testbench: clock, reset, byte stimulus and verdict.
// Depends on nls_pkg, nls_if, numeric_literal_scanner and nls_result_checker.
`timescale 1ns / 1ps

module numeric_literal_scanner_tb;
  import nls_pkg::*;

  localparam int CYCLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst;
  bit   gaps_on;
  bit   hold_req;
  int   sent;
  int   cycle_count;
  int   fail_count;
  int   pending_count;

  nls_byte_if   bytes_ch();
  nls_result_if res_ch();

  numeric_literal_scanner uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .result (res_ch)
  );

  nls_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .bytes         (bytes_ch),
    .result        (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("numeric_literal_scanner_tb NOT OK");
    $finish;
  end

  // The receiver stalls in short bursts, and for one long stretch when asked.
  initial begin
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      bytes_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.source_byte <= b;
    bytes_ch.end_of_input <= eoi;
    do @(posedge clk); while (bytes_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] dec_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return CH_ZERO + 8'(v);
    if (v < 16) return CH_LO_A + 8'(v - 10);
    return CH_UP_A + 8'(v - 16);
  endfunction

  task automatic add_exponent(ref logic [7:0] lit[$], input logic [7:0] mark);
    int n, s;
    lit.push_back(mark);
    s = $urandom_range(0, 2);
    if (s == 1) lit.push_back(CH_PLUS);
    if (s == 2) lit.push_back(CH_MINUS);
    n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) lit.push_back(dec_char());
  endtask

  task automatic add_suffix(ref logic [7:0] lit[$]);
    case ($urandom_range(0, 5))
      2: lit.push_back(CH_LO_I);
      3: lit.push_back(CH_LO_U);
      4: lit.push_back(CH_LO_F);
      5: lit.push_back(CH_LO_H);
      default: ;
    endcase
  endtask

  task automatic send_literal(input bit corrupt);
    logic [7:0] lit[$];
    int         kind, n;
    kind = $urandom_range(0, 5);
    if (kind <= 2) begin
      lit.push_back($urandom_range(0, 4) == 0 ? CH_ZERO : CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(0, 3)) lit.push_back(dec_char());
      if (kind == 1) begin
        lit.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) lit.push_back(dec_char());
      end
      if (kind == 2 || (kind == 1 && $urandom_range(0, 1) == 1))
        add_exponent(lit, $urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
    end else if (kind == 3) begin
      lit.push_back(CH_DOT);
      n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
      repeat (n) lit.push_back(dec_char());
      if ($urandom_range(0, 1) == 1) add_exponent(lit, $urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
    end else begin
      lit.push_back(CH_ZERO);
      lit.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
      repeat (n) lit.push_back(hex_char());
      if (kind == 5) begin
        if ($urandom_range(0, 2) != 0) begin
          lit.push_back(CH_DOT);
          repeat ($urandom_range(0, 3)) lit.push_back(hex_char());
        end
        if ($urandom_range(0, 2) != 0) add_exponent(lit, $urandom_range(0, 1) ? CH_LO_P : CH_UP_P);
      end
    end
    add_suffix(lit);
    if (corrupt) lit[$urandom_range(0, lit.size() - 1)] = 8'($urandom_range(0, 255));
    foreach (lit[i]) send_byte(lit[i], 1'b0);
    case ($urandom_range(0, 5))
      0: send_byte(8'($urandom_range(0, 255)), 1'b1);
      1: send_byte(";", 1'b0);
      2: send_byte(",", 1'b0);
      3: send_byte(")", 1'b0);
      4: send_byte(8'h0A, 1'b0);
      default: send_byte(" ", 1'b0);
    endcase
  endtask

  task automatic random_step(input bit allow_gaps);
    int r;
    gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
    r = $urandom_range(0, 9);
    if (r < 8) begin
      send_literal(1'b0);
    end else if (r == 8) begin
      send_literal(1'b1);
    end else begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic drain();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
  endtask

  initial begin
    int mark;
    rst <= 1'b1;
    bytes_ch.valid <= 1'b0;
    bytes_ch.source_byte <= '0;
    bytes_ch.end_of_input <= 1'b0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text(".;");
    send_text("00;");
    send_text("1e+;");
    send_text("0x;");
    send_text("0x.;");
    send_text("0x1.;");
    send_text("0x1h");

    mark = sent;
    while (sent - mark < 180) random_step(1'b1);

    // Hold the results back while requests keep coming, then let everything drain.
    hold_req = 1'b1;
    repeat (4) send_literal(1'b0);
    drain();

    mark = sent;
    while (sent - mark < 110) random_step(1'b1);
    mark = sent;
    while (sent - mark < 50) random_step(1'b0);

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("numeric_literal_scanner_tb OK");
    end else begin
      $display("numeric_literal_scanner_tb NOT OK");
    end
    $finish;
  end

endmodule
